/* hdl/fab_pkg.sv */
// Shared types, constants and register codes for the frame accumulation blend block.
package fab_pkg;

  localparam int MAX_PIXELS = 4194304;
  localparam int POS_W      = $clog2(MAX_PIXELS);
  localparam int SIZE_W     = POS_W + 1;
  localparam int DIM_W      = 12;
  localparam int CH_W       = 8;
  localparam int NUM_CH     = 3;
  localparam int PIX_W      = NUM_CH * CH_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = DIM_W;
  localparam int MODE_W     = 2;

  localparam logic [MODE_W-1:0] MODE_MAX = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ADD = 2'd1;
  localparam logic [MODE_W-1:0] MODE_MUL = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;

  localparam logic [DIM_W-1:0] WIDTH_RST  = 12'd640;
  localparam logic [DIM_W-1:0] HEIGHT_RST = 12'd480;
  localparam logic [DIM_W-1:0] DIM_MAX    = 12'd2048;

  localparam logic [CH_W-1:0] CH_FULL = 8'hff;

  typedef logic [NUM_CH-1:0][CH_W-1:0] pix_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [DIM_W-1:0]  width;
    logic [DIM_W-1:0]  height;
  } cfg_t;

  typedef struct packed {
    logic [POS_W-1:0] addr;
    logic             first;
    logic             last;
  } pos_t;

endpackage

/* hdl/fab_if.sv */
// Valid/ready stream interfaces for pixel input and blended output.
interface fab_in_if;
  logic       valid;
  logic       ready;
  logic       restart;
  logic [7:0] chan0_in;
  logic [7:0] chan1_in;
  logic [7:0] chan2_in;

  modport source (output valid, restart, chan0_in, chan1_in, chan2_in, input ready);
  modport sink   (input valid, restart, chan0_in, chan1_in, chan2_in, output ready);
endinterface

interface fab_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] chan0_out;
  logic [7:0] chan1_out;
  logic [7:0] chan2_out;
  logic       frame_end;

  modport source (output valid, chan0_out, chan1_out, chan2_out, frame_end, input ready);
  modport sink   (input valid, chan0_out, chan1_out, chan2_out, frame_end, output ready);
endinterface

/* hdl/frame_accumulation_blend_top.sv */
// Top level of the frame accumulation blend block.
//
//   port        dir  beat contents
//   pix_in      in   restart, chan0_in, chan1_in, chan2_in
//   pix_out     out  chan0_out, chan1_out, chan2_out, frame_end
//   cfg_*       in   cfg_idx_i selects mode / frame_width / frame_height
//
// One pixel per clock sustained while pix_out.ready stays high; a beat is registered in stage one, then in stage two.
// Stage one reads the accumulator RAM, combines and writes back; stage two holds the output beat.
// A write and a read of the same entry in one cycle are resolved by forwarding.
// Reset clears position and valid flags, sets the first-frame flag and loads config defaults; the RAM is not cleared.
// An output stall backs up one beat in stage one, then drops pix_in.ready.
module frame_accumulation_blend_top import fab_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  fab_in_if.sink                pix_in,
  fab_out_if.source             pix_out
);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{mode: MODE_MAX, width: WIDTH_RST, height: HEIGHT_RST};
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_MODE:   cfg_q.mode   <= cfg_wdata_i[MODE_W-1:0];
        REG_WIDTH:  cfg_q.width  <= cfg_wdata_i[DIM_W-1:0];
        REG_HEIGHT: cfg_q.height <= cfg_wdata_i[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  logic in_acc, s1_move;
  pos_t pos_info;

  logic             s1_v_q;
  logic [POS_W-1:0] s1_addr_q;
  logic             s1_first_q, s1_last_q;
  pix_t             s1_src_q;
  logic             s1_fwd_v_q, s1_fwd_v_d;
  pix_t             s1_fwd_q;

  logic             s2_v_q;
  pix_t             s2_pix_q;
  logic             s2_last_q;

  logic [PIX_W-1:0] rdata;
  pix_t             acc, result, src_in;

  assign s1_move      = s1_v_q && (!s2_v_q || pix_out.ready);
  assign pix_in.ready = !s1_v_q || s1_move;
  assign in_acc       = pix_in.valid && pix_in.ready;
  assign src_in       = {pix_in.chan2_in, pix_in.chan1_in, pix_in.chan0_in};

  fab_pos u_pos (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .accept_i (in_acc),
    .restart_i(pix_in.restart),
    .pos_o    (pos_info)
  );

  fab_ram #(.DEPTH(MAX_PIXELS), .WIDTH(PIX_W)) u_ram (
    .clk_i  (clk_i),
    .we_i   (s1_move),
    .waddr_i(s1_addr_q),
    .wdata_i(result),
    .re_i   (in_acc && !pos_info.first),
    .raddr_i(pos_info.addr),
    .rdata_o(rdata)
  );

  always_comb begin
    if (s1_first_q) begin
      acc = (cfg_q.mode == MODE_MUL) ? {NUM_CH{CH_FULL}} : '0;
    end else if (s1_fwd_v_q) begin
      acc = s1_fwd_q;
    end else begin
      acc = rdata;
    end
  end

  fab_blend u_blend (
    .mode_i(cfg_q.mode),
    .src_i (s1_src_q),
    .acc_i (acc),
    .res_o (result)
  );

  assign s1_fwd_v_d = s1_move && (s1_addr_q == pos_info.addr);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q     <= 1'b0;
      s1_fwd_v_q <= 1'b0;
      s2_v_q     <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_v_q     <= 1'b1;
        s1_fwd_v_q <= s1_fwd_v_d;
      end else if (s1_move) begin
        s1_v_q     <= 1'b0;
        s1_fwd_v_q <= 1'b0;
      end
      if (s1_move) begin
        s2_v_q <= 1'b1;
      end else if (pix_out.ready) begin
        s2_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_addr_q  <= pos_info.addr;
      s1_first_q <= pos_info.first;
      s1_last_q  <= pos_info.last;
      s1_src_q   <= src_in;
      s1_fwd_q   <= result;
    end
    if (s1_move) begin
      s2_pix_q  <= result;
      s2_last_q <= s1_last_q;
    end
  end

  assign pix_out.valid     = s2_v_q;
  assign pix_out.chan0_out = s2_pix_q[0];
  assign pix_out.chan1_out = s2_pix_q[1];
  assign pix_out.chan2_out = s2_pix_q[2];
  assign pix_out.frame_end = s2_last_q;

  a_ready_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pix_in.ready |-> (s1_v_q && s2_v_q && !pix_out.ready))
    else $error("input stalled without a full pipeline");

  a_frame_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && pos_info.last) |=> (pos_info.addr == '0))
    else $error("position did not return to zero after frame end");

  a_fwd_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && s1_fwd_v_d) |=> (s1_v_q && s2_v_q))
    else $error("forwarded data without a preceding write");

  a_out_from_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(s2_v_q) |-> $past(s1_v_q))
    else $error("output beat without a stage-one item");

endmodule

/* hdl/fab_ram.sv */
// Simple dual-port RAM, one write and one registered read port.
module fab_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 24,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/fab_pos.sv */
// Raster position tracker: frame size, current address, first-frame and end-of-frame flags.
module fab_pos import fab_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  cfg_t cfg_i,
  input  logic accept_i,
  input  logic restart_i,
  output pos_t pos_o
);

  logic [POS_W-1:0]   pos_q, pos_d;
  logic               first_q, first_d;
  logic [SIZE_W-1:0]  size;
  logic [DIM_W-1:0]   w_clamp, h_clamp;
  logic [2*DIM_W-1:0] prod;
  logic [POS_W-1:0]   addr;
  logic               first, last;

  always_comb begin
    w_clamp = (cfg_i.width == '0) ? DIM_W'(1) :
              (cfg_i.width > DIM_MAX) ? DIM_MAX : cfg_i.width;
    h_clamp = (cfg_i.height == '0) ? DIM_W'(1) :
              (cfg_i.height > DIM_MAX) ? DIM_MAX : cfg_i.height;
    prod    = w_clamp * h_clamp;
    size    = (32'(prod) > 32'(MAX_PIXELS)) ? SIZE_W'(MAX_PIXELS) : SIZE_W'(prod);
  end

  always_comb begin
    addr    = restart_i ? '0 : pos_q;
    first   = restart_i | first_q;
    last    = {1'b0, addr} >= (size - SIZE_W'(1));
    pos_d   = pos_q;
    first_d = first_q;
    if (accept_i) begin
      pos_d   = last ? '0 : addr + POS_W'(1);
      first_d = last ? 1'b0 : first;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      first_q <= 1'b1;
    end else begin
      pos_q   <= pos_d;
      first_q <= first_d;
    end
  end

  assign pos_o = '{addr: addr, first: first, last: last};

endmodule

/* hdl/fab_blend.sv */
// Per-channel combine of source and stored pixel: maximum, saturating add, scaled multiply.
module fab_blend import fab_pkg::*; (
  input  logic [MODE_W-1:0] mode_i,
  input  pix_t              src_i,
  input  pix_t              acc_i,
  output pix_t              res_o
);

  logic [NUM_CH-1:0][CH_W:0]     sum;
  logic [NUM_CH-1:0][2*CH_W-1:0] prod;
  logic [NUM_CH-1:0][2*CH_W:0]   quot;

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      sum[c]  = {1'b0, src_i[c]} + {1'b0, acc_i[c]};
      prod[c] = src_i[c] * acc_i[c];
      // floor(x / 255) for x up to 255 * 255
      quot[c] = {1'b0, prod[c]} + (2*CH_W+1)'(prod[c][2*CH_W-1:CH_W]) + (2*CH_W+1)'(1);
      case (mode_i)
        MODE_MAX: res_o[c] = (src_i[c] > acc_i[c]) ? src_i[c] : acc_i[c];
        MODE_ADD: res_o[c] = sum[c][CH_W] ? CH_FULL : sum[c][CH_W-1:0];
        MODE_MUL: res_o[c] = quot[c][2*CH_W-1:CH_W];
        default:  res_o[c] = '0;
      endcase
    end
  end

endmodule
